>>> rtl/cfir_pkg.sv
// Shared types, codes and helpers for the centered FIR filter.
// Used by cfir_cell, cfir_ctrl and centered_fir_filter_unit; no dependencies.
package cfir_pkg;

	localparam int DATA_W = 32;
	localparam int CMD_W = 2;
	localparam int COEF_IDX_W = 4;
	localparam int TAPS_REG_W = 5;
	localparam int MODE_W = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 5;
	localparam int S_TDATA_W = 72;

	localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IN_MODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MODE = 2'd2;

	localparam logic [MODE_W-1:0] WMODE_8 = 2'd0;
	localparam logic [MODE_W-1:0] WMODE_16 = 2'd1;
	localparam logic [MODE_W-1:0] WMODE_32 = 2'd2;

	// Per-cycle strobes from the sequencer to every cell.
	typedef struct packed {
		logic shift;   // push a new sample into the delay line
		logic clear;   // zero the delay line
		logic coef_we; // coefficient write
		logic copy;    // snapshot delay line into the work chain
		logic rotate;  // rotate the work chain by one cell
		logic mul;     // register the per-cell products
		logic sum;     // advance the partial-sum chain
	} cfir_ctrl_t;

	// Keep the low 8 or 16 bits and sign-extend; anything else passes 32 bits.
	function automatic logic [DATA_W-1:0] narrow(input logic [DATA_W-1:0] v,
		input logic [MODE_W-1:0] mode);
		logic [DATA_W-1:0] r;
		unique case (mode)
			WMODE_8: r = {{(DATA_W-8){v[7]}}, v[7:0]};
			WMODE_16: r = {{(DATA_W-16){v[15]}}, v[15:0]};
			default: r = v;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/cfir_cell.sv
// One tap cell: delay-line entry, coefficient, rotating work entry,
// registered product and one step of the partial-sum chain. Uses cfir_pkg.
module cfir_cell #(
	parameter int MAX_TAPS = 16,
	parameter int IDX = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfir_pkg::cfir_ctrl_t          ctrl,
	input  logic [$clog2(MAX_TAPS+1)-1:0] rot_steps,
	input  logic [3:0]                    coef_index,
	input  logic [31:0]                   coef_value,
	input  logic [31:0]                   hist_in,
	output logic [31:0]                   hist_out,
	input  logic [31:0]                   copy_in,
	output logic [31:0]                   copy_out,
	input  logic [31:0]                   sum_in,
	output logic [31:0]                   sum_out
);
	import cfir_pkg::*;

	localparam int CW = $clog2(MAX_TAPS + 1);
	// Coefficients sit in reverse order so that a plain rotation lines them up.
	localparam int COEF_SLOT = MAX_TAPS - 1 - IDX;

	logic [DATA_W-1:0] hist_q;
	logic [DATA_W-1:0] coef_q;
	logic [DATA_W-1:0] copy_q;
	logic [DATA_W-1:0] prod_q;
	logic [DATA_W-1:0] sum_q;
	logic [DATA_W-1:0] prod_d;
	logic              coef_hit;
	logic              active;

	assign coef_hit = (int'(coef_index) == COEF_SLOT);
	// Cells below the rotation distance carry coefficients past tap_count.
	assign active = (CW'(IDX) >= rot_steps);
	assign prod_d = coef_q * copy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
			coef_q <= '0;
		end else begin
			if (ctrl.clear) begin
				hist_q <= '0;
			end else if (ctrl.shift) begin
				hist_q <= hist_in;
			end
			if (ctrl.coef_we && coef_hit) begin
				coef_q <= coef_value;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.copy) begin
			copy_q <= hist_q;
		end else if (ctrl.rotate) begin
			copy_q <= copy_in;
		end
		if (ctrl.mul) begin
			prod_q <= active ? prod_d : '0;
		end
		if (ctrl.sum) begin
			sum_q <= sum_in + prod_q;
		end
	end

	assign hist_out = hist_q;
	assign copy_out = copy_q;
	assign sum_out = sum_q;

endmodule

>>> rtl/cfir_ctrl.sv
// Sequencer for the tap chain: decodes commands, steps the rotate, multiply
// and sum phases and hands the result to the output register. Uses cfir_pkg.
module cfir_ctrl #(
	parameter int MAX_TAPS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [1:0]                    cmd,
	input  logic [$clog2(MAX_TAPS+1)-1:0] rot_steps,
	input  logic                          out_free,
	output logic                          out_load,
	output cfir_pkg::cfir_ctrl_t          ctrl
);
	import cfir_pkg::*;

	localparam int CW = $clog2(MAX_TAPS + 1);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_COPY = 6'b000010,
		ST_ROT  = 6'b000100,
		ST_MUL  = 6'b001000,
		ST_SUM  = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	state_t        state_q;
	state_t        state_d;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cnt_d;
	logic          xfer;

	assign s_tready = (state_q == ST_IDLE);
	assign xfer = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		ctrl = '0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (xfer) begin
					unique case (cmd)
						CMD_LOAD: ctrl.coef_we = 1'b1;
						CMD_SAMPLE: begin
							ctrl.shift = 1'b1;
							state_d = ST_COPY;
						end
						CMD_CLEAR: ctrl.clear = 1'b1;
						default: ;
					endcase
				end
			end
			ST_COPY: begin
				ctrl.copy = 1'b1;
				cnt_d = rot_steps;
				state_d = (rot_steps == '0) ? ST_MUL : ST_ROT;
			end
			ST_ROT: begin
				ctrl.rotate = 1'b1;
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				ctrl.mul = 1'b1;
				cnt_d = CW'(MAX_TAPS);
				state_d = ST_SUM;
			end
			ST_SUM: begin
				// partial sum walks one cell per cycle down the chain
				ctrl.sum = 1'b1;
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
		end
	end

	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && cmd == CMD_SAMPLE) |=> !s_tready)
		else $error("sample transfer did not start a computation");

	a_other_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && cmd != CMD_SAMPLE) |=> s_tready)
		else $error("non-sample command left the sequencer busy");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("result loaded over an untaken result");

	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROT || state_q == ST_SUM) |-> cnt_q != '0)
		else $error("phase counter ran out inside a counted phase");

endmodule

>>> rtl/centered_fir_filter_unit.sv
// Centered FIR filter top level: config registers, input narrowing, tap-cell
// chain and output register. Depends on cfir_pkg, cfir_cell and cfir_ctrl.
//
// Usage:
//   Input stream s_*: tuser carries the command (load coefficient, filter
//   sample, clear history); tdata carries coefficient index, coefficient value
//   and sample. Output stream m_*: one filtered value per sample command.
//   Config channel cfg_*: register index and data, always ready; write only
//   while the block is idle.
// Sequence:
//   Load and clear are handled without leaving the idle state. A sample runs
//   through copy, rotation of the work chain by D = MAX_TAPS - min(tap_count,
//   MAX_TAPS) cells, multiply, the partial-sum walk along the cell chain and
//   the output load. One item is in flight at a time; the next is accepted
//   the cycle after its result is loaded.
// Reset: history and coefficients zero, tap_count 1, both widths 32 bits.
// Stall: a waiting result holds in the output register; a finished next
//   result waits in the sequencer until the register frees up.
module centered_fir_filter_unit #(
	parameter int MAX_TAPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // [3:0] coef_index, [35:4] coef_value,
	                              // [67:36] sample, [71:68] zero
	input  logic [1:0]  s_tuser,  // [1:0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [31:0] filtered
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [4:0]  cfg_data
);
	import cfir_pkg::*;

	localparam int CW = $clog2(MAX_TAPS + 1);

	logic [TAPS_REG_W-1:0] tap_count_q;
	logic [MODE_W-1:0]     in_mode_q;
	logic [MODE_W-1:0]     out_mode_q;
	logic                  m_tvalid_q;
	logic [DATA_W-1:0]     m_tdata_q;

	logic [CW-1:0]         taps_eff;
	logic [CW-1:0]         rot_steps;
	logic [DATA_W-1:0]     new_sample;
	logic                  out_free;
	logic                  out_load;
	cfir_ctrl_t            ctrl;

	logic [DATA_W-1:0] hist_w [MAX_TAPS];
	logic [DATA_W-1:0] copy_w [MAX_TAPS];
	logic [DATA_W-1:0] sum_w  [MAX_TAPS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TAPS_REG_W'(1);
			in_mode_q <= WMODE_32;
			out_mode_q <= WMODE_32;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TAP_COUNT: tap_count_q <= cfg_data;
				REG_IN_MODE: in_mode_q <= cfg_data[MODE_W-1:0];
				REG_OUT_MODE: out_mode_q <= cfg_data[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (int'(tap_count_q) > MAX_TAPS) begin
			taps_eff = CW'(MAX_TAPS);
		end else begin
			taps_eff = CW'(tap_count_q);
		end
	end

	// Rotating the work chain by this much pairs coefficient j with sample age
	// tap_count-1-j.
	assign rot_steps = CW'(MAX_TAPS) - taps_eff;
	assign new_sample = narrow(s_tdata[67:36], in_mode_q);

	cfir_ctrl #(
		.MAX_TAPS(MAX_TAPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (s_tuser),
		.rot_steps(rot_steps),
		.out_free (out_free),
		.out_load (out_load),
		.ctrl     (ctrl)
	);

	for (genvar m = 0; m < MAX_TAPS; m++) begin : g_cell
		logic [DATA_W-1:0] hist_in;
		logic [DATA_W-1:0] copy_in;
		logic [DATA_W-1:0] sum_in;

		if (m == 0) begin : g_head
			assign hist_in = new_sample;
			assign copy_in = copy_w[MAX_TAPS-1];
			assign sum_in = '0;
		end else begin : g_body
			assign hist_in = hist_w[m-1];
			assign copy_in = copy_w[m-1];
			assign sum_in = sum_w[m-1];
		end

		cfir_cell #(
			.MAX_TAPS(MAX_TAPS),
			.IDX     (m)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.rot_steps (rot_steps),
			.coef_index(s_tdata[3:0]),
			.coef_value(s_tdata[35:4]),
			.hist_in   (hist_in),
			.hist_out  (hist_w[m]),
			.copy_in   (copy_in),
			.copy_out  (copy_w[m]),
			.sum_in    (sum_in),
			.sum_out   (sum_w[m])
		);
	end

	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= narrow(sum_w[MAX_TAPS-1], out_mode_q);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

endmodule

>>> verif/centered_fir_filter_unit_tb.sv
// Self-checking testbench for centered_fir_filter_unit: a clocked driver and monitor
// around the block, an in-bench FIR predictor, directed and random phases.
// Depends on rtl/cfir_pkg.sv and the filter RTL only.
module centered_fir_filter_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cfir_pkg::*;

	localparam int TAP_DEPTH = 16;
	localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;   // not decoded by the block
	localparam logic [MODE_W-1:0] MODE_ALT32 = 2'd3; // unused code, acts as 32 bits
	localparam int SETTLE_CYCLES = 3 * TAP_DEPTH + 10;

	typedef struct {
		logic [CMD_W-1:0]      cmd;
		logic [COEF_IDX_W-1:0] idx;
		logic [DATA_W-1:0]     cval;
		logic [DATA_W-1:0]     smp;
		bit                    drain; // hold off until all results are back
	} fir_item_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [71:0]       s_tdata = '0;  // [3:0] coef_index, [35:4] coef_value,
	                                  // [67:36] sample, [71:68] zero
	logic [1:0]        s_tuser = '0;  // [1:0] cmd
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [31:0]       m_tdata;       // [31:0] filtered
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [1:0]        cfg_index = '0;
	logic [4:0]        cfg_data = '0;

	// predictor state
	logic [DATA_W-1:0]     coef_mem [TAP_DEPTH];
	logic [DATA_W-1:0]     hist_mem [TAP_DEPTH];
	logic [TAPS_REG_W-1:0] fir_taps = 5'd1;
	logic [MODE_W-1:0]     in_mode = WMODE_32;
	logic [MODE_W-1:0]     out_mode = WMODE_32;

	fir_item_t         pend_q[$];
	logic [DATA_W-1:0] filt_q[$];
	fir_item_t         tx_item;

	int burst_left = 0;
	int gap_left = 0;
	int stall_pos = 0;
	logic [15:0] stall_word = '1;
	int err_cnt = 0;
	int n_results = 0;
	int n_samples = 0;
	int n_loads = 0;
	int n_clears = 0;
	int n_ignored = 0;
	int n_settings = 0;

	centered_fir_filter_unit #(.MAX_TAPS(TAP_DEPTH)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		for (int k = 0; k < TAP_DEPTH; k++) begin
			coef_mem[k] = '0;
			hist_mem[k] = '0;
		end
	end

	function automatic logic [DATA_W-1:0] sext_to(input logic [DATA_W-1:0] v,
		input logic [MODE_W-1:0] mode);
		case (mode)
			WMODE_8: return 32'($signed(v[7:0]));
			WMODE_16: return 32'($signed(v[15:0]));
			default: return v;
		endcase
	endfunction

	// Applies one accepted item to the predictor; returns 1 when a result is due.
	function automatic bit fir_accept(input fir_item_t it, output logic [DATA_W-1:0] res);
		int n;
		logic [DATA_W-1:0] acc;
		res = '0;
		case (it.cmd)
			CMD_LOAD: begin
				coef_mem[it.idx] = it.cval;
				return 1'b0;
			end
			CMD_CLEAR: begin
				for (int k = 0; k < TAP_DEPTH; k++)
					hist_mem[k] = '0;
				return 1'b0;
			end
			CMD_SAMPLE: begin
				for (int k = TAP_DEPTH - 1; k > 0; k--)
					hist_mem[k] = hist_mem[k-1];
				hist_mem[0] = sext_to(it.smp, in_mode);
				n = (fir_taps > TAP_DEPTH) ? TAP_DEPTH : int'(fir_taps);
				acc = '0;
				for (int j = 0; j < n; j++)
					acc += coef_mem[j] * hist_mem[n-1-j];
				res = sext_to(acc, out_mode);
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// Sender: bursts of random length with random gaps.
	always @(posedge clk) begin : drive_in
		logic [DATA_W-1:0] res;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				if (fir_accept(tx_item, res))
					filt_q.push_back(res);
				case (tx_item.cmd)
					CMD_LOAD: n_loads++;
					CMD_SAMPLE: n_samples++;
					CMD_CLEAR: n_clears++;
					default: n_ignored++;
				endcase
			end
			if (!(s_tvalid && !s_tready)) begin
				if (gap_left != 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pend_q.size() == 0 || (pend_q[0].drain && filt_q.size() != 0)) begin
					s_tvalid <= 1'b0;
				end else begin
					tx_item = pend_q.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= tx_item.cmd;
					s_tdata <= {4'b0000, tx_item.smp, tx_item.cval, tx_item.idx};
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						if ($urandom_range(0, 3) == 0) begin
							burst_left = $urandom_range(20, 60);
							gap_left = 0;
						end else begin
							burst_left = $urandom_range(1, 8);
							gap_left = $urandom_range(1, 12);
						end
					end
				end
			end
		end
	end

	// Receiver: stall pattern walks a random 16-bit word, sometimes no stall at all.
	always @(posedge clk) begin : watch_out
		logic [DATA_W-1:0] want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (filt_q.size() == 0) begin
					$error("filtered: expected nothing, actual %h", m_tdata);
					err_cnt++;
				end else begin
					want = filt_q.pop_front();
					n_results++;
					if (m_tdata !== want) begin
						$error("filtered: expected %h, actual %h", want, m_tdata);
						err_cnt++;
					end
				end
			end
			if (stall_pos == 15) begin
				stall_pos = 0;
				stall_word = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
			end else begin
				stall_pos++;
			end
			m_tready <= stall_word[stall_pos];
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_TAP_COUNT: fir_taps = val;
			REG_IN_MODE: in_mode = val[MODE_W-1:0];
			REG_OUT_MODE: out_mode = val[MODE_W-1:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic set_regs(input logic [4:0] taps, input logic [1:0] im, input logic [1:0] om);
		write_reg(REG_TAP_COUNT, taps);
		write_reg(REG_IN_MODE, {3'b000, im});
		write_reg(REG_OUT_MODE, {3'b000, om});
		n_settings++;
	endtask

	// Wait for the stream to drain, then cover loads/clears still in the pipe.
	task automatic settle();
		do @(posedge clk); while (pend_q.size() != 0 || s_tvalid || filt_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic push_item(input logic [1:0] cmd, input logic [3:0] idx,
		input logic [31:0] cval, input logic [31:0] smp, input bit drain = 1'b0);
		fir_item_t it;
		it.cmd = cmd;
		it.idx = idx;
		it.cval = cval;
		it.smp = smp;
		it.drain = drain;
		pend_q.push_back(it);
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'($urandom_range(0, 16)) - 32'd8;
			3: return {16'($urandom), 8'($urandom_range(0, 1) ? 8'h7F : 8'h80), 8'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	task automatic random_phase(input int n_items);
		int r;
		if ($urandom_range(0, 1) == 1)
			for (int k = 0; k < TAP_DEPTH; k++)
				push_item(CMD_LOAD, 4'(k), pick_word(), $urandom);
		for (int i = 0; i < n_items; i++) begin
			r = $urandom_range(0, 99);
			if (r < 14)
				push_item(CMD_LOAD, 4'($urandom_range(0, 15)), pick_word(), $urandom);
			else if (r < 18)
				push_item(CMD_CLEAR, 4'($urandom), $urandom, $urandom);
			else if (r < 20)
				push_item(CMD_NONE, 4'($urandom), $urandom, $urandom);
			else
				push_item(CMD_SAMPLE, 4'($urandom), $urandom, pick_word(),
					$urandom_range(0, 149) == 0);
		end
	endtask

	initial begin : stimulus
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: one tap, 32-bit both ways
		push_item(CMD_SAMPLE, 4'd0, 32'd0, 32'h7FFF_FFFF);
		push_item(CMD_LOAD, 4'd0, 32'h8000_0000, 32'hFFFF_FFFF);
		push_item(CMD_LOAD, 4'd15, 32'h7FFF_FFFF, 32'd0);
		push_item(CMD_SAMPLE, 4'd15, 32'h7FFF_FFFF, 32'h8000_0000);
		push_item(CMD_SAMPLE, 4'd0, 32'd0, 32'hFFFF_FFFF);
		push_item(CMD_NONE, 4'd0, 32'hDEAD_BEEF, 32'h0000_0005);
		push_item(CMD_SAMPLE, 4'd0, 32'd0, 32'h0000_0001);
		push_item(CMD_CLEAR, 4'd0, 32'd0, 32'd0);
		push_item(CMD_SAMPLE, 4'd0, 32'd0, 32'h1234_5678);
		settle();

		// all taps, byte samples and results
		set_regs(5'd16, WMODE_8, WMODE_8);
		push_item(CMD_LOAD, 4'd1, 32'hFFFF_FFFF, 32'd0);
		push_item(CMD_SAMPLE, 4'd0, 32'd0, 32'h0000_007F);
		push_item(CMD_SAMPLE, 4'd0, 32'd0, 32'hFFFF_FF80);
		push_item(CMD_SAMPLE, 4'd0, 32'd0, 32'hABCD_EF80);
		push_item(CMD_CLEAR, 4'd0, 32'd0, 32'd0);
		push_item(CMD_SAMPLE, 4'd0, 32'd0, 32'h0000_0080);
		settle();

		// empty sum
		set_regs(5'd0, WMODE_16, WMODE_16);
		push_item(CMD_SAMPLE, 4'd0, 32'd0, 32'h0000_8000);
		push_item(CMD_SAMPLE, 4'd0, 32'd0, 32'hFFFF_7FFF);
		settle();

		// tap count above the depth saturates; width code 3 means 32 bits
		set_regs(5'd31, MODE_ALT32, MODE_ALT32);
		push_item(CMD_LOAD, 4'd15, 32'h0000_0003, 32'd0);
		push_item(CMD_SAMPLE, 4'd0, 32'd0, 32'h7FFF_FFFF);
		push_item(CMD_SAMPLE, 4'd0, 32'd0, 32'h8000_0000);
		push_item(CMD_SAMPLE, 4'd0, 32'd0, 32'hFFFF_FFFF, 1'b1);
		settle();

		set_regs(5'd1, WMODE_32, WMODE_32);    random_phase(90);  settle();
		set_regs(5'd16, WMODE_8, WMODE_8);     random_phase(90);  settle();
		set_regs(5'd16, WMODE_16, WMODE_16);   random_phase(90);  settle();
		set_regs(5'd0, WMODE_32, WMODE_8);     random_phase(40);  settle();
		set_regs(5'd31, MODE_ALT32, MODE_ALT32); random_phase(90); settle();
		set_regs(5'd8, WMODE_8, WMODE_32);     random_phase(90);  settle();
		set_regs(5'd3, WMODE_32, WMODE_8);     random_phase(90);  settle();
		set_regs(5'd17, MODE_ALT32, WMODE_16); random_phase(90);  settle();
		set_regs(5'd2, WMODE_16, MODE_ALT32);  random_phase(90);  settle();
		for (int p = 0; p < 4; p++) begin
			set_regs(5'($urandom_range(0, 31)), 2'($urandom_range(0, 3)),
				2'($urandom_range(0, 3)));
			random_phase(85);
			settle();
		end

		if (filt_q.size() != 0) begin
			$error("filtered: %0d expected results never arrived", filt_q.size());
			err_cnt++;
		end
		$display("Covered %0d samples, %0d coefficient loads, %0d clears, %0d ignored commands",
			n_samples, n_loads, n_clears, n_ignored);
		$display("across %0d register settings; %0d filtered values checked, %0d mismatches",
			n_settings, n_results, err_cnt);
		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : watchdog
		#10ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
